FILE: rtl/opvp_pkg.sv
package opvp_pkg;

	// Timestamp width default
	localparam int TIME_WIDTH_DEF = 32;

	// Field widths
	localparam int CFG_W   = 16;
	localparam int MV_W    = 13;
	localparam int MA_W    = 16;
	localparam int NOW_W   = 32;
	localparam int OUT_W   = 16;
	localparam int S_TDATA_W = 64;
	localparam int M_TDATA_W = 40;
	localparam int CFG_IDX_W = 3;

	// Internal voltage width: 8191 * 65535 / 256000 stays below 2^12
	localparam int VOLT_W  = 12;

	// Voltage scaling: floor(mv*gain / 256000) = floor((mv*gain >> 11) / 125)
	localparam int PROD1_W = MV_W + CFG_W;
	localparam int DIVX_W  = PROD1_W - 11;
	localparam int RECIP_V_W = 19;
	localparam int RECIP_V_SHIFT = 25;
	localparam logic [RECIP_V_W-1:0] RECIP_V = 19'd268436;
	localparam int QV_W    = DIVX_W + RECIP_V_W;

	// Power scaling: floor(ma*v / 1000) = floor((ma*v >> 3) / 125)
	localparam int PROD2_W = MA_W + VOLT_W;
	localparam int DIVY_W  = PROD2_W - 3;
	localparam int RECIP_P_W = 26;
	localparam int RECIP_P_SHIFT = 32;
	localparam logic [RECIP_P_W-1:0] RECIP_P = 26'd34359739;
	localparam int QP_W    = DIVY_W + RECIP_P_W;
	localparam int QP_INT_W = QP_W - RECIP_P_SHIFT;

	// Power compare width: 65535 * 11 fits 20 bits
	localparam int PCMP_W  = 20;

	// Voltage thresholds
	localparam logic [VOLT_W-1:0] V0_HIGH  = 12'd550;
	localparam logic [VOLT_W-1:0] V0_LOW   = 12'd150;
	localparam logic [VOLT_W-1:0] V0_UNDER = 12'd30;
	localparam logic [VOLT_W-1:0] V1_HIGH  = 12'd300;
	localparam logic [VOLT_W-1:0] V1_UNDER = 12'd15;

	// Register reset values
	localparam logic [CFG_W-1:0] GAIN_RST  = 16'd37120;
	localparam logic [CFG_W-1:0] LIMIT_RST = 16'd1200;
	localparam logic [CFG_W-1:0] LONG_RST  = 16'd1000;
	localparam logic [CFG_W-1:0] SHORT_RST = 16'd200;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN_CH0   = 3'd0,
		CFG_GAIN_CH1   = 3'd1,
		CFG_LIMIT_CH0  = 3'd2,
		CFG_LIMIT_CH1  = 3'd3,
		CFG_LONG_TRIP  = 3'd4,
		CFG_SHORT_TRIP = 3'd5
	} cfg_idx_t;

	typedef enum logic [2:0] {
		FC_NONE       = 3'd0,
		FC_CH0_WINDOW = 3'd1,
		FC_CH0_UNDER  = 3'd2,
		FC_CH0_POWER  = 3'd3,
		FC_CH1_OVER   = 3'd4,
		FC_CH1_UNDER  = 3'd5,
		FC_CH1_POWER  = 3'd6
	} fault_code_t;

	typedef enum logic [1:0] {
		CLS_NORMAL = 2'd0,
		CLS_WINDOW = 2'd1,
		CLS_SHORT  = 2'd2
	} fault_class_t;

	typedef enum logic [1:0] {
		TRIP_NONE  = 2'd0,
		TRIP_LONG  = 2'd1,
		TRIP_SHORT = 2'd2
	} trip_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV1,
		ST_MUL2,
		ST_DIV2,
		ST_JUDGE
	} state_t;

	typedef struct packed {
		logic [CFG_W-1:0] gain_ch0;
		logic [CFG_W-1:0] gain_ch1;
		logic [CFG_W-1:0] limit_ch0;
		logic [CFG_W-1:0] limit_ch1;
		logic [CFG_W-1:0] long_trip;
		logic [CFG_W-1:0] short_trip;
	} cfg_t;

	typedef struct packed {
		logic capture;
		logic div1;
		logic mul2;
		logic div2;
		logic judge;
	} dp_cmd_t;

endpackage

FILE: rtl/output_voltage_power_protection.sv
// Sequence from input transfer to output valid: three scale steps, then writeback.
// One item at a time: a new input is taken only in idle, after writeback; the sequencer steps the
// two chained multiply and reciprocal-divide steps through one shared set of stage registers.
// A waiting result does not block the next input; writeback stalls only while it waits.
// Reset (arst_n low, asynchronous): registers to defaults, timers, arm flags, latched trips
// and last fault code cleared, output empty.
module output_voltage_power_protection #(
	parameter int TIME_WIDTH = opvp_pkg::TIME_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// reading_mv[12:0], current_ma[28:13], now_ms[60:29], run_enable[61],
	// channel_enable[62], zero[63]
	input  logic [opvp_pkg::S_TDATA_W-1:0]     s_tdata,
	// channel[0]
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// processed[0], voltage_v[16:1], power_w[32:17], fault_class[34:33],
	// fault_code[37:35], trip_result[39:38]
	output logic [opvp_pkg::M_TDATA_W-1:0]     m_tdata,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [opvp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [opvp_pkg::CFG_W-1:0]         cfg_data
);

	opvp_pkg::cfg_t    cfg;
	opvp_pkg::dp_cmd_t cmd;

	logic                          processed;
	logic [opvp_pkg::OUT_W-1:0]    voltage_v;
	logic [opvp_pkg::OUT_W-1:0]    power_w;
	logic [1:0]                    fault_class;
	logic [2:0]                    fault_code;
	logic [1:0]                    trip_result;

	opvp_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg_valid),
		.wr_ready (cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	opvp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	opvp_datapath #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg            (cfg),
		.channel        (s_tuser),
		.reading_mv     (s_tdata[12:0]),
		.current_ma     (s_tdata[28:13]),
		.now_ms         (s_tdata[60:29]),
		.run_enable     (s_tdata[61]),
		.channel_enable (s_tdata[62]),
		.processed      (processed),
		.voltage_v      (voltage_v),
		.power_w        (power_w),
		.fault_class    (fault_class),
		.fault_code     (fault_code),
		.trip_result    (trip_result)
	);

	// Pack result fields, highest first
	assign m_tdata = {trip_result, fault_code, fault_class, power_w, voltage_v, processed};

endmodule

FILE: rtl/opvp_cfg_regs.sv
module opvp_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_valid,
	output logic                            wr_ready,
	input  logic [opvp_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [opvp_pkg::CFG_W-1:0]      wr_data,
	output opvp_pkg::cfg_t                  cfg
);

	opvp_pkg::cfg_t cfg_q;

	assign wr_ready = 1'b1;
	assign cfg      = cfg_q;

	// Register file, written on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_ch0   <= opvp_pkg::GAIN_RST;
			cfg_q.gain_ch1   <= opvp_pkg::GAIN_RST;
			cfg_q.limit_ch0  <= opvp_pkg::LIMIT_RST;
			cfg_q.limit_ch1  <= opvp_pkg::LIMIT_RST;
			cfg_q.long_trip  <= opvp_pkg::LONG_RST;
			cfg_q.short_trip <= opvp_pkg::SHORT_RST;
		end else if (wr_valid && wr_ready) begin
			unique case (opvp_pkg::cfg_idx_t'(wr_index))
				opvp_pkg::CFG_GAIN_CH0:   cfg_q.gain_ch0   <= wr_data;
				opvp_pkg::CFG_GAIN_CH1:   cfg_q.gain_ch1   <= wr_data;
				opvp_pkg::CFG_LIMIT_CH0:  cfg_q.limit_ch0  <= wr_data;
				opvp_pkg::CFG_LIMIT_CH1:  cfg_q.limit_ch1  <= wr_data;
				opvp_pkg::CFG_LONG_TRIP:  cfg_q.long_trip  <= wr_data;
				opvp_pkg::CFG_SHORT_TRIP: cfg_q.short_trip <= wr_data;
				default: ;
			endcase
		end
	end

endmodule

FILE: rtl/opvp_ctrl.sv
module opvp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output opvp_pkg::dp_cmd_t  cmd
);

	opvp_pkg::state_t state_q, state_nx;
	logic             out_valid_q;
	logic             judge_go;

	assign out_valid = out_valid_q;
	assign in_ready  = (state_q == opvp_pkg::ST_IDLE);

	// Writeback only when the output register is free or being drained
	assign judge_go = (state_q == opvp_pkg::ST_JUDGE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= opvp_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_nx    = state_q;
		cmd         = '0;
		cmd.capture = in_valid && in_ready;
		unique case (state_q)
			opvp_pkg::ST_IDLE: begin
				if (in_valid) state_nx = opvp_pkg::ST_DIV1;
			end
			opvp_pkg::ST_DIV1: begin
				cmd.div1 = 1'b1;
				state_nx = opvp_pkg::ST_MUL2;
			end
			opvp_pkg::ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_nx = opvp_pkg::ST_DIV2;
			end
			opvp_pkg::ST_DIV2: begin
				cmd.div2 = 1'b1;
				state_nx = opvp_pkg::ST_JUDGE;
			end
			opvp_pkg::ST_JUDGE: begin
				cmd.judge = judge_go;
				if (judge_go) state_nx = opvp_pkg::ST_IDLE;
			end
			default: state_nx = opvp_pkg::ST_IDLE;
		endcase
	end

	// Output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (judge_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_accept_to_judge: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> ##4 (state_q == opvp_pkg::ST_JUDGE))
		else $error("item did not reach writeback four cycles after transfer");

	a_judge_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		judge_go |=> out_valid_q)
		else $error("writeback did not raise output valid");

	a_valid_from_judge: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == opvp_pkg::ST_JUDGE))
		else $error("output valid rose outside writeback");
`endif

endmodule

FILE: rtl/opvp_datapath.sv
module opvp_datapath #(
	parameter int TIME_WIDTH = opvp_pkg::TIME_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  opvp_pkg::dp_cmd_t             cmd,
	input  opvp_pkg::cfg_t                cfg,
	input  logic                          channel,
	input  logic [opvp_pkg::MV_W-1:0]     reading_mv,
	input  logic [opvp_pkg::MA_W-1:0]     current_ma,
	input  logic [opvp_pkg::NOW_W-1:0]    now_ms,
	input  logic                          run_enable,
	input  logic                          channel_enable,
	output logic                          processed,
	output logic [opvp_pkg::OUT_W-1:0]    voltage_v,
	output logic [opvp_pkg::OUT_W-1:0]    power_w,
	output logic [1:0]                    fault_class,
	output logic [2:0]                    fault_code,
	output logic [1:0]                    trip_result
);

	localparam int PW = opvp_pkg::PROD1_W;

	// Captured item
	logic                           ch_q;
	logic                           gate_q;
	logic [opvp_pkg::MA_W-1:0]      ma_q;
	logic [TIME_WIDTH-1:0]          now_q;
	logic [PW-1:0]                  prod1_q;
	logic [opvp_pkg::VOLT_W-1:0]    v_q;
	logic [opvp_pkg::PROD2_W-1:0]   prod2_q;
	logic [opvp_pkg::OUT_W-1:0]     p_q;

	// Per channel protection state and shared last fault code
	logic [TIME_WIDTH-1:0]          start_q [2];
	logic [1:0]                     armed_long_q;
	logic [1:0]                     armed_short_q;
	logic [1:0]                     latch_q [2];
	logic [2:0]                     last_code_q;

	// Output payload
	logic                           processed_q;
	logic [opvp_pkg::OUT_W-1:0]     voltage_q;
	logic [opvp_pkg::OUT_W-1:0]     power_q;
	logic [1:0]                     class_q;
	logic [2:0]                     code_q;
	logic [1:0]                     trip_q;

	logic [TIME_WIDTH+opvp_pkg::NOW_W-1:0] now_ext;
	logic [opvp_pkg::CFG_W-1:0]     gain_sel;
	logic [opvp_pkg::QV_W-1:0]      qv_full;
	logic [opvp_pkg::QP_W-1:0]      qp_full;
	logic [opvp_pkg::QP_INT_W-1:0]  qp_int;

	// Only the low TIME_WIDTH bits of the timestamp count
	assign now_ext  = {{TIME_WIDTH{1'b0}}, now_ms};
	assign gain_sel = channel ? cfg.gain_ch1 : cfg.gain_ch0;

	// Capture and first product
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ch_q    <= channel;
			gate_q  <= run_enable && channel_enable;
			ma_q    <= current_ma;
			now_q   <= now_ext[TIME_WIDTH-1:0];
			prod1_q <= PW'(reading_mv) * PW'(gain_sel);
		end
	end

	// Reciprocal multiplies for the divisions by 125
	assign qv_full = opvp_pkg::QV_W'(prod1_q[PW-1:11]) * opvp_pkg::QV_W'(opvp_pkg::RECIP_V);
	assign qp_full = opvp_pkg::QP_W'(prod2_q[opvp_pkg::PROD2_W-1:3])
		* opvp_pkg::QP_W'(opvp_pkg::RECIP_P);
	assign qp_int  = qp_full[opvp_pkg::QP_W-1:opvp_pkg::RECIP_P_SHIFT];

	always_ff @(posedge clk) begin
		if (cmd.div1) begin
			v_q <= qv_full[opvp_pkg::QV_W-1:opvp_pkg::RECIP_V_SHIFT];
		end
		if (cmd.mul2) begin
			prod2_q <= opvp_pkg::PROD2_W'(ma_q) * opvp_pkg::PROD2_W'(v_q);
		end
		if (cmd.div2) begin
			p_q <= (|qp_int[opvp_pkg::QP_INT_W-1:opvp_pkg::OUT_W]) ?
				{opvp_pkg::OUT_W{1'b1}} : qp_int[opvp_pkg::OUT_W-1:0];
		end
	end

	// Classification
	logic [opvp_pkg::CFG_W-1:0]     limit_sel;
	logic [opvp_pkg::PCMP_W-1:0]    pw10;
	logic [opvp_pkg::PCMP_W-1:0]    lim11;
	logic                           over_power;
	opvp_pkg::fault_class_t         cls;
	opvp_pkg::fault_code_t          code;

	always_comb begin
		limit_sel  = ch_q ? cfg.limit_ch1 : cfg.limit_ch0;
		pw10       = opvp_pkg::PCMP_W'({p_q, 3'b000}) + opvp_pkg::PCMP_W'({p_q, 1'b0});
		lim11      = opvp_pkg::PCMP_W'({limit_sel, 3'b000})
			+ opvp_pkg::PCMP_W'({limit_sel, 1'b0}) + opvp_pkg::PCMP_W'(limit_sel);
		over_power = pw10 > lim11;
		cls        = opvp_pkg::CLS_NORMAL;
		code       = opvp_pkg::FC_NONE;
		if (!ch_q) begin
			if (v_q >= opvp_pkg::V0_HIGH || v_q <= opvp_pkg::V0_LOW) begin
				cls  = opvp_pkg::CLS_WINDOW;
				code = opvp_pkg::FC_CH0_WINDOW;
			end else if (v_q <= opvp_pkg::V0_UNDER) begin
				// shadowed by the low window test, kept as specified
				cls  = opvp_pkg::CLS_SHORT;
				code = opvp_pkg::FC_CH0_UNDER;
			end else if (over_power) begin
				cls  = opvp_pkg::CLS_SHORT;
				code = opvp_pkg::FC_CH0_POWER;
			end
		end else begin
			if (v_q >= opvp_pkg::V1_HIGH) begin
				cls  = opvp_pkg::CLS_WINDOW;
				code = opvp_pkg::FC_CH1_OVER;
			end else if (v_q <= opvp_pkg::V1_UNDER) begin
				cls  = opvp_pkg::CLS_SHORT;
				code = opvp_pkg::FC_CH1_UNDER;
			end else if (over_power) begin
				cls  = opvp_pkg::CLS_SHORT;
				code = opvp_pkg::FC_CH1_POWER;
			end
		end
	end

	// Trip timers, next state
	logic [TIME_WIDTH-1:0]          elapsed;
	logic                           long_over;
	logic                           short_over;
	logic [TIME_WIDTH-1:0]          start_nx;
	logic                           arm_long_nx;
	logic                           arm_short_nx;
	logic [1:0]                     latch_nx;
	logic [2:0]                     last_code_nx;

	always_comb begin
		elapsed      = now_q - start_q[ch_q];
		long_over    = {{opvp_pkg::CFG_W{1'b0}}, elapsed} >
			{{TIME_WIDTH{1'b0}}, cfg.long_trip};
		short_over   = {{opvp_pkg::CFG_W{1'b0}}, elapsed} >
			{{TIME_WIDTH{1'b0}}, cfg.short_trip};
		start_nx     = start_q[ch_q];
		arm_long_nx  = armed_long_q[ch_q];
		arm_short_nx = armed_short_q[ch_q];
		latch_nx     = latch_q[ch_q];
		last_code_nx = last_code_q;
		if (gate_q) begin
			if (cls != opvp_pkg::CLS_NORMAL) last_code_nx = code;
			case (cls)
				opvp_pkg::CLS_WINDOW: begin
					if (!armed_long_q[ch_q]) begin
						start_nx    = now_q;
						arm_long_nx = 1'b1;
					end else if (long_over) begin
						latch_nx    = opvp_pkg::TRIP_LONG;
						arm_long_nx = 1'b0;
					end
				end
				opvp_pkg::CLS_SHORT: begin
					if (!armed_short_q[ch_q]) begin
						start_nx     = now_q;
						arm_short_nx = 1'b1;
					end else if (short_over) begin
						latch_nx     = opvp_pkg::TRIP_SHORT;
						arm_short_nx = 1'b0;
					end
				end
				default: begin
					if (latch_q[ch_q] == opvp_pkg::TRIP_NONE) begin
						arm_long_nx  = 1'b0;
						arm_short_nx = 1'b0;
					end
				end
			endcase
		end
	end

	// Protection state update at writeback
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q[0]    <= '0;
			start_q[1]    <= '0;
			armed_long_q  <= '0;
			armed_short_q <= '0;
			latch_q[0]    <= opvp_pkg::TRIP_NONE;
			latch_q[1]    <= opvp_pkg::TRIP_NONE;
			last_code_q   <= opvp_pkg::FC_NONE;
		end else if (cmd.judge) begin
			start_q[ch_q]       <= start_nx;
			armed_long_q[ch_q]  <= arm_long_nx;
			armed_short_q[ch_q] <= arm_short_nx;
			latch_q[ch_q]       <= latch_nx;
			last_code_q         <= last_code_nx;
		end
	end

	// Result register; voltage never exceeds 16 bits so no saturation there
	always_ff @(posedge clk) begin
		if (cmd.judge) begin
			processed_q <= gate_q;
			voltage_q   <= gate_q ? opvp_pkg::OUT_W'(v_q) : '0;
			power_q     <= gate_q ? p_q : '0;
			class_q     <= gate_q ? cls : opvp_pkg::CLS_NORMAL;
			code_q      <= last_code_nx;
			trip_q      <= latch_nx;
		end
	end

	assign processed   = processed_q;
	assign voltage_v   = voltage_q;
	assign power_w     = power_q;
	assign fault_class = class_q;
	assign fault_code  = code_q;
	assign trip_result = trip_q;

endmodule
